### rtl/ilr_pkg.sv
// shared types and constants for the integer line rasterizer
`default_nettype none

package ilr_pkg;

  // default coordinate width and depth of the command queue
  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 4;

  // command codes carried on the input tuser bit
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // classification of one queued command
  typedef struct packed {
    logic is_load;
    logic x_neg;
    logic y_neg;
    logic steep;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

`default_nettype wire

### rtl/ilr_front.sv
// front end: takes input beats, works out line setup for loads
`default_nettype none

module ilr_front #(
  parameter int COORD_BITS = ilr_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_cmd,
  input  wire logic [4*COORD_BITS-1:0] in_coords,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ilr_pkg::FLAGS_W+5*COORD_BITS+2:0] out_entry
);
  import ilr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  logic [CB-1:0] sx, sy, ex, ey;
  logic [CB-1:0] adx, ady, major, minor;
  logic          x_neg, y_neg, steep;
  logic [EW-1:0] err_flat, err_steep, err_init;
  cmd_flags_t    flags;
  logic          full_valid;
  logic          take;

  assign sx = in_coords[CB-1:0];
  assign sy = in_coords[2*CB-1:CB];
  assign ex = in_coords[3*CB-1:2*CB];
  assign ey = in_coords[4*CB-1:3*CB];

  // absolute deltas and step signs
  always_comb begin
    x_neg = ex < sx;
    y_neg = ey < sy;
    adx   = x_neg ? (sx - ex) : (ex - sx);
    ady   = y_neg ? (sy - ey) : (ey - sy);
    steep = adx < ady;
    major = steep ? ady : adx;
    minor = steep ? adx : ady;
    // both candidates for 2*minor - major, picked by steep
    err_flat  = {2'b00, ady, 1'b0} - {3'b000, adx};
    err_steep = {2'b00, adx, 1'b0} - {3'b000, ady};
    err_init  = steep ? err_steep : err_flat;
    flags.is_load = (cmd_t'(in_cmd) == CMD_LOAD);
    flags.x_neg   = x_neg;
    flags.y_neg   = y_neg;
    flags.steep   = steep;
  end

  assign in_ready  = !full_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = full_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_valid <= 1'b0;
    end else if (take) begin
      full_valid <= 1'b1;
    end else if (out_ready) begin
      full_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_entry <= {flags, sx, sy, major, minor, err_init};
    end
  end

endmodule

`default_nettype wire

### rtl/ilr_queue.sv
// small flop-based fifo between the front and back ends
`default_nettype none

module ilr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ilr_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);
  import ilr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/ilr_back.sv
// back end: line state, one bresenham step per step command, output register
`default_nettype none

module ilr_back #(
  parameter int COORD_BITS = ilr_pkg::COORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  input  wire logic [ilr_pkg::FLAGS_W+5*COORD_BITS+2:0] cmd_entry,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [COORD_BITS-1:0]  res_x,
  output logic [COORD_BITS-1:0]  res_y,
  output logic                   res_last,
  output logic                   res_real
);
  import ilr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  cmd_flags_t    e_flags;
  logic [CB-1:0] e_sx, e_sy, e_major, e_minor;
  logic [EW-1:0] e_err;

  // line state
  logic [CB-1:0] cur_x, cur_y, major_len, minor_len, remaining;
  logic [EW-1:0] err_term;
  logic          step_x_neg, step_y_neg, steep, active;

  logic [CB-1:0] cur_x_next, cur_y_next, remaining_next;
  logic [EW-1:0] err_term_next;
  logic          active_next;
  logic          err_ge0, mov_x, mov_y;
  logic [EW-1:0] err_mid;
  logic [CB-1:0] o_x, o_y;
  logic          o_last, o_real;

  assign {e_flags, e_sx, e_sy, e_major, e_minor, e_err} = cmd_entry;

  assign cmd_pop = cmd_valid && (!res_valid || res_ready);

  always_comb begin
    err_ge0        = !err_term[EW-1];
    mov_x          = steep ? err_ge0 : 1'b1;
    mov_y          = steep ? 1'b1 : err_ge0;
    err_mid        = err_ge0 ? (err_term - {2'b00, major_len, 1'b0}) : err_term;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    err_term_next  = err_term;
    remaining_next = remaining;
    active_next    = active;
    o_x            = '0;
    o_y            = '0;
    o_last         = 1'b0;
    o_real         = 1'b0;
    if (e_flags.is_load) begin
      cur_x_next     = e_sx;
      cur_y_next     = e_sy;
      err_term_next  = e_err;
      remaining_next = e_major;
      active_next    = (e_major != '0);
      o_x            = e_sx;
      o_y            = e_sy;
      o_last         = (e_major == '0);
      o_real         = 1'b1;
    end else if (active && remaining != '0) begin
      if (mov_x) begin
        cur_x_next = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (mov_y) begin
        cur_y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      err_term_next  = err_mid + {2'b00, minor_len, 1'b0};
      remaining_next = remaining - 1'b1;
      active_next    = (remaining != CB'(1));
      o_x            = cur_x_next;
      o_y            = cur_y_next;
      o_last         = (remaining == CB'(1));
      o_real         = 1'b1;
    end else begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      err_term   <= '0;
      major_len  <= '0;
      minor_len  <= '0;
      remaining  <= '0;
      step_x_neg <= 1'b0;
      step_y_neg <= 1'b0;
      steep      <= 1'b0;
      active     <= 1'b0;
    end else if (cmd_pop) begin
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      err_term  <= err_term_next;
      remaining <= remaining_next;
      active    <= active_next;
      if (e_flags.is_load) begin
        major_len  <= e_major;
        minor_len  <= e_minor;
        step_x_neg <= e_flags.x_neg;
        step_y_neg <= e_flags.y_neg;
        steep      <= e_flags.steep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_x    <= o_x;
      res_y    <= o_y;
      res_last <= o_last;
      res_real <= o_real;
    end
  end

endmodule

`default_nettype wire

### rtl/integer_line_rasterizer_unit.sv
// top level of the integer line rasterizer
`default_nettype none

// bresenham line rasterizer for all octants, one pixel per command beat.
// a load beat (tuser = 0) latches start point and setup and returns the start
// pixel; each step beat (tuser = 1) returns the next pixel, tlast marks the
// end point, and a step with no line in progress returns a beat with tuser = 0
// and zero data. a zero-length load returns one pixel with tlast set.
// throughput is one beat per clock in both directions while m_tready is high
// and the queue is not full; the pixel for a beat passes through the front
// register, a queue slot and the output register before it is presented. the
// rate is set by the step update in the back end, one add and compare on the
// registered error term per cycle. a four-entry queue sits between the
// setup front end and the stepping back end so either side can stall alone.
module integer_line_rasterizer_unit #(
  parameter int COORD_BITS = ilr_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  // input stream
  input  wire logic s_tvalid,
  output logic      s_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // cmd: 0 load, 1 step
  input  wire logic s_tuser,
  // output stream
  output logic      m_tvalid,
  input  wire logic m_tready,
  // pixel_x, pixel_y from bit 0 up, zero padded to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // valid_res: 1 for a real pixel
  output logic      m_tuser,
  // last pixel of the line
  output logic      m_tlast
);
  import ilr_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int ENTRY_W = FLAGS_W + 5*COORD_BITS + 3;
  localparam int OUT_W   = ((2*COORD_BITS+7)/8)*8;

  logic               f_valid, q_full, q_not_empty, q_pop;
  logic [ENTRY_W-1:0] f_entry, q_entry;
  logic [CB-1:0]      px, py;

  // front end: setup math for loads, registered
  ilr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_coords (s_tdata[4*CB-1:0]),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_entry (f_entry)
  );

  // decoupling queue of classified commands
  ilr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .not_empty (q_not_empty)
  );

  // back end: line state and stepping, drives the output register
  ilr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .cmd_entry (q_entry),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_x     (px),
    .res_y     (py),
    .res_last  (m_tlast),
    .res_real  (m_tuser)
  );

  // pack pixel coordinates, upper pad bits zero
  assign m_tdata = OUT_W'({py, px});

endmodule

`default_nettype wire
